// ----- sv/b2s_pkg.sv -----
package b2s_pkg;

  localparam int COEF_W = 32;
  localparam int WIDE_W = 2 * COEF_W + 2;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef struct packed {
    coef_t num0;
    coef_t num1;
    coef_t num2;
    coef_t den1;
    coef_t den2;
  } biquad_t;

  typedef struct packed {
    coef_t high_mix;
    coef_t band_mix;
    coef_t low_mix;
    coef_t integrator_gain;
    coef_t feedback_coef;
    coef_t resolve_scale;
    logic  invalid;
  } svf_t;

  // Sign-extend a coefficient to the wide working format.
  function automatic wide_t widen(input coef_t x);
    return wide_t'(x);
  endfunction

  // Clamp a wide value into the coefficient range.
  function automatic coef_t sat(input wide_t x);
    wide_t hi;
    wide_t lo;
    hi = wide_t'(COEF_MAX);
    lo = wide_t'(COEF_MIN);
    if (x > hi) begin
      return COEF_MAX;
    end
    if (x < lo) begin
      return COEF_MIN;
    end
    return coef_t'(x[COEF_W-1:0]);
  endfunction

endpackage

// ----- sv/biquad_to_svf_coefficients.sv -----
// Biquad to state variable filter coefficient converter. Each transaction
// carries one set of direct-form biquad coefficients (b0, b1, b2, a1, a2 in
// signed Q8.24) and yields one set of state variable filter coefficients:
// highpass, bandpass and lowpass mix gains, integrator gain g, feedback
// coefficient c and resolving scale 1/(1+g*c). The block is fully pipelined:
// busy stays low, a new transaction is taken on every cycle that start is
// high, and each result appears on svf, also in signed Q8.24, for one cycle
// with done high, in the order the transactions were taken. The receiver
// cannot stall the block, so done must be captured when it is seen. The
// latency is set by the critical path through the pipeline:
// a restoring divider for 1/(-T), the square root, then two more dividers in
// series, each a chain of cells that settles one quotient or root bit per
// cycle. When T is not negative, or any divisor is zero, invalid is set and
// all six coefficients read zero. Every intermediate saturates.
module biquad_to_svf_coefficients #(
  parameter int FRAC_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  b2s_pkg::biquad_t biquad,
  output logic             done,
  output b2s_pkg::svf_t    svf
);
  import b2s_pkg::*;

  // Pipeline timing: cycle at which each value sits in its register.
  localparam int LD  = COEF_W + 2;
  localparam int SQB = (COEF_W + FRAC_BITS) / 2;
  localparam int LS  = SQB + 2;
  localparam int T_S = 4 + LD + LS;
  localparam int T_A = T_S + 2;
  localparam int T_E = T_A + 2 * LD + 4;

  localparam wide_t ONE_W     = wide_t'(1) <<< FRAC_BITS;
  localparam coef_t ONE_Q     = coef_t'(ONE_W[COEF_W-1:0]);
  localparam coef_t NEG_ONE_Q = coef_t'(-ONE_W);

  logic accept;
  logic [T_E:0] stb;

  coef_t t1, t2, nh, nb, nl, n2;
  coef_t t, negt;
  logic  tnn;
  coef_t inv, s_root;
  logic  dz_inv;
  coef_t t_d, t1_d, nb_d, n2_d;
  coef_t ts, t1s, sb;
  coef_t ah, al;
  logic  dz_ah, dz_al;
  coef_t r, g, g_d1, c, gc, den, sc;
  logic  dz_r, dz_g, dz_sc;

  logic [2*COEF_W-1:0] t1nb_d;
  logic [2*COEF_W+1:0] ahal_d;
  logic [COEF_W+1:0]   g_dd;
  logic [COEF_W-1:0]   c_d, sb_d;
  logic                tnn_d, dz_inv_d;
  logic                ok;
  svf_t                svf_next;

  // Take a transaction every cycle; nothing ever holds the pipeline.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Advance the result strobe alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      stb <= '0;
    end else begin
      stb <= {stb[T_E-1:0], accept};
    end
  end

  assign done = stb[T_E];

  // Sums and differences of the input coefficients, each saturated once.
  always_ff @(posedge clk) begin
    t1 <= sat(widen(biquad.den1) - widen(biquad.den2) - ONE_W);
    t2 <= sat(widen(biquad.den1) + widen(biquad.den2) + ONE_W);
    nh <= sat(-(widen(biquad.num0) - widen(biquad.num1) + widen(biquad.num2)));
    nb <= sat(widen(biquad.num0) - widen(biquad.num2));
    nl <= sat(widen(biquad.num0) + widen(biquad.num1) + widen(biquad.num2));
    n2 <= sat((widen(biquad.den2) - ONE_W) <<< 1);
  end

  // T = T1*T2
  b2s_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_t (.clk(clk), .a(t1), .b(t2), .p(t));

  // Flag non-negative T and form the divisor -T.
  always_ff @(posedge clk) begin
    negt <= sat(-widen(t));
    tnn  <= !t[COEF_W-1];
  end

  // Mix gains for highpass and lowpass start right away and wait at the end.
  b2s_div #(.FRAC_BITS(FRAC_BITS)) u_div_ah (.clk(clk), .n(nh), .d(t1), .q(ah), .dz(dz_ah));
  b2s_div #(.FRAC_BITS(FRAC_BITS)) u_div_al (.clk(clk), .n(nl), .d(t2), .q(al), .dz(dz_al));

  // S = sqrt(1/(-T))
  b2s_div #(.FRAC_BITS(FRAC_BITS)) u_div_inv (
    .clk(clk), .n(ONE_Q), .d(negt), .q(inv), .dz(dz_inv)
  );
  b2s_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (.clk(clk), .x(inv), .r(s_root));

  // Align T, T1 and b0-b2 with S, and 2*(a2-1) with T*S.
  b2s_delay #(.WIDTH(COEF_W), .DEPTH(T_S - 3)) u_dly_t (.clk(clk), .d(t), .q(t_d));
  b2s_delay #(.WIDTH(2 * COEF_W), .DEPTH(T_S - 1)) u_dly_t1nb (
    .clk(clk), .d({t1, nb}), .q(t1nb_d)
  );
  assign t1_d = t1nb_d[2*COEF_W-1:COEF_W];
  assign nb_d = t1nb_d[COEF_W-1:0];
  b2s_delay #(.WIDTH(COEF_W), .DEPTH(T_A - 1)) u_dly_n2 (.clk(clk), .d(n2), .q(n2_d));

  b2s_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ts  (.clk(clk), .a(t_d),    .b(s_root), .p(ts));
  b2s_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_t1s (.clk(clk), .a(t1_d),   .b(s_root), .p(t1s));
  b2s_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_sb  (.clk(clk), .a(s_root), .b(nb_d),   .p(sb));

  // r = 2*(a2-1)/(T*S), g = -1/(T1*S)
  b2s_div #(.FRAC_BITS(FRAC_BITS)) u_div_r (.clk(clk), .n(n2_d), .d(ts), .q(r), .dz(dz_r));
  b2s_div #(.FRAC_BITS(FRAC_BITS)) u_div_g (
    .clk(clk), .n(NEG_ONE_Q), .d(t1s), .q(g), .dz(dz_g)
  );

  // c = g + r; register g alongside c so the two meet at the multiplier.
  always_ff @(posedge clk) begin
    c    <= sat(widen(g) + widen(r));
    g_d1 <= g;
  end

  b2s_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_gc (.clk(clk), .a(g_d1), .b(c), .p(gc));

  always_ff @(posedge clk) begin
    den <= sat(ONE_W + widen(gc));
  end

  // s = 1/(1+g*c)
  b2s_div #(.FRAC_BITS(FRAC_BITS)) u_div_sc (.clk(clk), .n(ONE_Q), .d(den), .q(sc), .dz(dz_sc));

  // Hold the early results until the resolving scale arrives.
  b2s_delay #(.WIDTH(2 * COEF_W + 2), .DEPTH(T_E - 1 - LD)) u_dly_ahal (
    .clk(clk), .d({ah, dz_ah, al, dz_al}), .q(ahal_d)
  );
  b2s_delay #(.WIDTH(1), .DEPTH(T_E - 4)) u_dly_tnn (.clk(clk), .d(tnn), .q(tnn_d));
  b2s_delay #(.WIDTH(1), .DEPTH(T_E - 4 - LD)) u_dly_dzinv (
    .clk(clk), .d(dz_inv), .q(dz_inv_d)
  );
  b2s_delay #(.WIDTH(COEF_W), .DEPTH(T_E - T_A)) u_dly_sb (.clk(clk), .d(sb), .q(sb_d));
  b2s_delay #(.WIDTH(COEF_W + 2), .DEPTH(LD + 4)) u_dly_g (
    .clk(clk), .d({g, dz_r, dz_g}), .q(g_dd)
  );
  b2s_delay #(.WIDTH(COEF_W), .DEPTH(LD + 3)) u_dly_c (.clk(clk), .d(c), .q(c_d));

  // Gather the failure flags; an invalid conversion drives all coefficients to zero.
  assign ok = !(tnn_d | dz_inv_d | ahal_d[COEF_W+1] | ahal_d[0] |
                g_dd[1] | g_dd[0] | dz_sc);

  always_comb begin
    svf_next.high_mix        = ok ? coef_t'(ahal_d[2*COEF_W+1:COEF_W+2]) : '0;
    svf_next.band_mix        = ok ? sat(widen(coef_t'(sb_d)) <<< 1) : '0;
    svf_next.low_mix         = ok ? coef_t'(ahal_d[COEF_W:1]) : '0;
    svf_next.integrator_gain = ok ? coef_t'(g_dd[COEF_W+1:2]) : '0;
    svf_next.feedback_coef   = ok ? coef_t'(c_d) : '0;
    svf_next.resolve_scale   = ok ? sc : '0;
    svf_next.invalid         = !ok;
  end

  always_ff @(posedge clk) begin
    svf <= svf_next;
  end

endmodule

// ----- sv/b2s_delay.sv -----
module b2s_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    taps[0] <= d;
    for (int i = 1; i < DEPTH; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// ----- sv/b2s_mul.sv -----
module b2s_mul #(
  parameter int FRAC_BITS = 24
) (
  input  logic          clk,
  input  b2s_pkg::coef_t a,
  input  b2s_pkg::coef_t b,
  output b2s_pkg::coef_t p
);
  import b2s_pkg::*;

  localparam wide_t HALF = wide_t'(1) <<< (FRAC_BITS - 1);

  logic signed [2*COEF_W-1:0] prod;
  wide_t                      rnd;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // Round to nearest, ties toward plus infinity.
  assign rnd = (wide_t'(prod) + HALF) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    p <= sat(rnd);
  end

endmodule

// ----- sv/b2s_div.sv -----
module b2s_div #(
  parameter int FRAC_BITS = 24
) (
  input  logic           clk,
  input  b2s_pkg::coef_t n,
  input  b2s_pkg::coef_t d,
  output b2s_pkg::coef_t q,
  output logic           dz
);
  import b2s_pkg::*;

  localparam int RW = 2 * COEF_W + 2;

  logic [COEF_W-1:0] un;
  logic [COEF_W-1:0] ud;
  logic [RW-1:0]     num;
  logic [RW-1:0]     dvs;

  logic [RW-1:0]     s_rem [COEF_W+1];
  logic [RW-1:0]     s_den [COEF_W+1];
  logic [COEF_W-1:0] s_q   [COEF_W+1];
  logic              s_neg [COEF_W+1];
  logic              s_dz  [COEF_W+1];
  logic              s_ovf [COEF_W+1];

  logic [COEF_W-1:0] qf;
  logic              big;
  coef_t             q_next;

  // Rounded quotient = floor((2|n|*2^F + |d|) / (2|d|)).
  assign un  = n[COEF_W-1] ? (~n + 1'b1) : n;
  assign ud  = d[COEF_W-1] ? (~d + 1'b1) : d;
  assign num = (RW'(un) << (FRAC_BITS + 1)) + RW'(ud);
  assign dvs = RW'(ud) << 1;

  always_ff @(posedge clk) begin
    s_rem[0] <= num;
    s_den[0] <= dvs;
    s_q[0]   <= '0;
    s_neg[0] <= n[COEF_W-1] ^ d[COEF_W-1];
    s_dz[0]  <= (d == '0);
    s_ovf[0] <= (num >= (dvs << COEF_W));
  end

  // One quotient bit per cell, most significant first.
  for (genvar i = 1; i <= COEF_W; i++) begin : g_cell
    localparam int B = COEF_W - i;
    localparam logic [COEF_W-1:0] QBIT = COEF_W'(1) << B;
    logic [RW-1:0] trial;
    logic          take;

    assign trial = s_den[i-1] << B;
    assign take  = (s_rem[i-1] >= trial);

    always_ff @(posedge clk) begin
      s_rem[i] <= take ? (s_rem[i-1] - trial) : s_rem[i-1];
      s_q[i]   <= take ? (s_q[i-1] | QBIT) : s_q[i-1];
      s_den[i] <= s_den[i-1];
      s_neg[i] <= s_neg[i-1];
      s_dz[i]  <= s_dz[i-1];
      s_ovf[i] <= s_ovf[i-1];
    end
  end

  assign qf  = s_q[COEF_W];
  assign big = s_ovf[COEF_W] | qf[COEF_W-1];

  always_comb begin
    if (s_dz[COEF_W]) begin
      q_next = '0;
    end else if (s_neg[COEF_W]) begin
      q_next = big ? COEF_MIN : coef_t'(~qf + 1'b1);
    end else begin
      q_next = big ? COEF_MAX : coef_t'(qf);
    end
  end

  always_ff @(posedge clk) begin
    q  <= q_next;
    dz <= s_dz[COEF_W];
  end

endmodule

// ----- sv/b2s_sqrt.sv -----
module b2s_sqrt #(
  parameter int FRAC_BITS = 24
) (
  input  logic           clk,
  input  b2s_pkg::coef_t x,
  output b2s_pkg::coef_t r
);
  import b2s_pkg::*;

  localparam int SQB = (COEF_W + FRAC_BITS) / 2;
  localparam int SW  = 2 * SQB + 2;

  logic [SW-1:0]  s_rem  [SQB+1];
  logic [SQB:0]   s_root [SQB+1];
  logic [SQB:0]   r_fin;

  // Non-positive input gives zero.
  always_ff @(posedge clk) begin
    s_rem[0]  <= (x[COEF_W-1] || x == '0) ? '0 : (SW'(x) << FRAC_BITS);
    s_root[0] <= '0;
  end

  // One root bit per cell, most significant first; hold the remainder v - r*r.
  for (genvar i = 1; i <= SQB; i++) begin : g_cell
    localparam int K = SQB - i;
    localparam logic [SQB:0] RBIT = (SQB+1)'(1) << K;
    logic [SW-1:0] trial;
    logic          take;

    assign trial = (SW'(s_root[i-1]) << (K + 1)) + (SW'(1) << (2 * K));
    assign take  = (s_rem[i-1] >= trial);

    always_ff @(posedge clk) begin
      s_rem[i]  <= take ? (s_rem[i-1] - trial) : s_rem[i-1];
      s_root[i] <= take ? (s_root[i-1] | RBIT) : s_root[i-1];
    end
  end

  // Round to nearest: bump when the remainder exceeds the root.
  assign r_fin = (s_rem[SQB] > SW'(s_root[SQB])) ? (s_root[SQB] + 1'b1) : s_root[SQB];

  always_ff @(posedge clk) begin
    r <= sat(wide_t'(r_fin));
  end

endmodule

// ----- tb/tb_biquad_to_svf_coefficients.sv -----
module tb_biquad_to_svf_coefficients;
  timeunit 1ns;
  timeprecision 1ps;

  import b2s_pkg::*;

  localparam int FRAC = 24;
  localparam longint ONE_Q = longint'(1) << FRAC;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int LATENCY = 143;
  // Worst stall plus full pipeline drain, several times over.
  localparam int WATCHDOG_LIMIT = 20 * LATENCY;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  biquad_t biquad = '0;
  svf_t svf;

  biquad_to_svf_coefficients #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .biquad(biquad), .done(done), .svf(svf)
  );

  always #5 clk = ~clk;

  biquad_t coef_sets[$];   // sets waiting to be driven
  svf_t    expected_svf[$];  // predicted results, oldest first
  bit      failed = 1'b0;
  bit      calm = 1'b0;      // no idling while set
  bit      took = 1'b0;      // set presented last cycle was taken
  int      idle_cycles = 0;

  // Clamp to the coefficient range.
  function automatic longint clamp(longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  // Fixed-point product, rounded half up, then clamped.
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b + (longint'(1) << (FRAC - 1));
    return clamp(p >>> FRAC);
  endfunction

  // Fixed-point quotient, rounded half away from zero; ok cleared on a zero divisor.
  function automatic longint fx_div(longint n, longint d, inout bit ok);
    longint unsigned un, ud, q;
    bit neg;
    if (d == 0) begin
      ok = 1'b0;
      return 0;
    end
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    un = un << FRAC;
    q = (2 * un + ud) / (2 * ud);
    if (q > longint'(VMAX) + 1) q = longint'(VMAX) + 1;
    return clamp(neg ? -longint'(q) : longint'(q));
  endfunction

  // Root of x * 2^FRAC, rounded to nearest.
  function automatic longint fx_sqrt(longint x);
    longint unsigned v, r, b;
    if (x <= 0) return 0;
    v = longint'(x) << FRAC;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (v > r) r = r + 1;
    return clamp(longint'(r));
  endfunction

  // Convert one biquad to its state variable filter coefficients.
  function automatic svf_t convert_biquad(biquad_t bq);
    longint b0, b1, b2, a1, a2, t1, t2, t, inv, sr, ts, r, ah, ab, al, g, c, den, sc;
    bit ok;
    svf_t res;
    b0 = bq.num0; b1 = bq.num1; b2 = bq.num2; a1 = bq.den1; a2 = bq.den2;
    ok = 1'b1;
    t1 = clamp(a1 - a2 - ONE_Q);
    t2 = clamp(a1 + a2 + ONE_Q);
    t = fx_mul(t1, t2);
    if (t >= 0) ok = 1'b0;
    inv = fx_div(ONE_Q, clamp(-t), ok);
    sr = fx_sqrt(inv);
    ts = fx_mul(t, sr);
    r = fx_div(clamp(2 * (a2 - ONE_Q)), ts, ok);
    ah = fx_div(clamp(-(b0 - b1 + b2)), t1, ok);
    ab = clamp(2 * fx_mul(sr, clamp(b0 - b2)));
    al = fx_div(clamp(b0 + b1 + b2), t2, ok);
    g = fx_div(-ONE_Q, fx_mul(t1, sr), ok);
    c = clamp(g + r);
    den = clamp(ONE_Q + fx_mul(g, c));
    sc = fx_div(ONE_Q, den, ok);
    res = '0;
    if (ok) begin
      res.high_mix = coef_t'(ah);
      res.band_mix = coef_t'(ab);
      res.low_mix = coef_t'(al);
      res.integrator_gain = coef_t'(g);
      res.feedback_coef = coef_t'(c);
      res.resolve_scale = coef_t'(sc);
    end
    res.invalid = !ok;
    return res;
  endfunction

  // Driver: present the next set at the falling edge, idling about a third of the time.
  always @(negedge clk) begin
    if (!rst) begin
      if ((!start || took) && coef_sets.size() > 0 &&
          (calm || $urandom_range(99) >= 33)) begin
        biquad <= coef_sets.pop_front();
        start <= 1'b1;
      end else if (!start || took) begin
        start <= 1'b0;
      end
    end
  end

  // Sample the handshake at the rising edge.
  always @(posedge clk) begin
    took <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      expected_svf.push_back(convert_biquad(biquad));
    end
  end

  // Monitor: compare each strobed result with the oldest prediction.
  always @(posedge clk) begin
    svf_t want;
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (expected_svf.size() == 0) begin
          $error("result with no transaction pending");
          failed = 1'b1;
        end else begin
          want = expected_svf.pop_front();
          if (svf.high_mix !== want.high_mix) begin
            $error("high_mix exp %0d got %0d", want.high_mix, svf.high_mix); failed = 1'b1;
          end
          if (svf.band_mix !== want.band_mix) begin
            $error("band_mix exp %0d got %0d", want.band_mix, svf.band_mix); failed = 1'b1;
          end
          if (svf.low_mix !== want.low_mix) begin
            $error("low_mix exp %0d got %0d", want.low_mix, svf.low_mix); failed = 1'b1;
          end
          if (svf.integrator_gain !== want.integrator_gain) begin
            $error("integrator_gain exp %0d got %0d", want.integrator_gain,
                   svf.integrator_gain);
            failed = 1'b1;
          end
          if (svf.feedback_coef !== want.feedback_coef) begin
            $error("feedback_coef exp %0d got %0d", want.feedback_coef,
                   svf.feedback_coef);
            failed = 1'b1;
          end
          if (svf.resolve_scale !== want.resolve_scale) begin
            $error("resolve_scale exp %0d got %0d", want.resolve_scale,
                   svf.resolve_scale);
            failed = 1'b1;
          end
          if (svf.invalid !== want.invalid) begin
            $error("invalid exp %0b got %0b", want.invalid, svf.invalid); failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog: stop when nothing moves for too long.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Random coefficient near a typical filter value, or any 32-bit pattern.
  function automatic coef_t rand_coef(int lim_q);
    if ($urandom_range(9) == 0) return coef_t'($urandom);
    return coef_t'($signed($urandom_range(2 * lim_q)) - lim_q);
  endfunction

  // Stable biquad: poles inside the unit circle give a valid conversion.
  function automatic biquad_t stable_biquad();
    biquad_t bq;
    int a2, lim;
    a2 = $signed($urandom_range(2 * 16000000)) - 16000000;
    lim = (16777216 + a2) - 1;
    bq.den2 = coef_t'(a2);
    bq.den1 = coef_t'($signed($urandom_range(2 * lim)) - lim);
    bq.num0 = rand_coef(64000000);
    bq.num1 = rand_coef(64000000);
    bq.num2 = rand_coef(64000000);
    return bq;
  endfunction

  function automatic biquad_t mk(coef_t n0, coef_t n1, coef_t n2, coef_t d1, coef_t d2);
    biquad_t bq;
    bq.num0 = n0; bq.num1 = n1; bq.num2 = n2; bq.den1 = d1; bq.den2 = d2;
    return bq;
  endfunction

  initial begin
    biquad_t bq;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, nonnegative T, zero divisors, a plain lowpass.
    coef_sets.push_back(mk('0, '0, '0, '0, '0));
    coef_sets.push_back(mk(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX));
    coef_sets.push_back(mk(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN));
    coef_sets.push_back(mk(COEF_MAX, COEF_MIN, COEF_MAX, '0, '0));
    coef_sets.push_back(mk(COEF_MIN, COEF_MAX, COEF_MIN, '0, '0));
    coef_sets.push_back(mk(32'sd16777216, '0, '0, '0, 32'sd16777216));   // a2 = 1, so 2*(a2-1) is zero
    coef_sets.push_back(mk(32'sd16777216, '0, '0, '0, -32'sd16777216));  // T1 and T2 zero
    coef_sets.push_back(mk(32'sd16777216, '0, '0, 32'sd50000000, '0));   // T positive
    coef_sets.push_back(mk(32'sd16777216, '0, '0, '0, 32'sd16777215));   // a2 just below one
    coef_sets.push_back(mk(32'sd1000000, 32'sd2000000, 32'sd1000000,
                           -32'sd25000000, 32'sd10000000));
    coef_sets.push_back(mk(32'sd16777216, -32'sd33554432, 32'sd16777216,
                           -32'sd30000000, 32'sd14000000));
    coef_sets.push_back(mk(32'sd16777216, '0, -32'sd16777216, '0, -32'sd16000000));
    coef_sets.push_back(mk(-32'sd1, 32'sd1, -32'sd1, 32'sd1, -32'sd1));
    for (int i = 0; i < 8; i++) coef_sets.push_back(stable_biquad());

    // Random: mostly stable filters, some raw noise; a calm stretch in the middle.
    for (int i = 0; i < 1650; i++) begin
      if ($urandom_range(3) == 0) begin
        bq = mk(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom),
                coef_t'($urandom), coef_t'($urandom));
      end else begin
        bq = stable_biquad();
      end
      coef_sets.push_back(bq);
    end

    wait (coef_sets.size() < 1000);
    calm = 1'b1;
    wait (coef_sets.size() < 700);
    calm = 1'b0;
    wait (coef_sets.size() == 0);
    @(negedge clk);
    wait (expected_svf.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
